// ===== rtl/vn2d_pkg.sv =====
// ----------------------------------------------------------------------------
// vn2d_pkg: shared types and constants for the 2d value noise pipeline
// coordinate format, hash multipliers and pipeline geometry
// ----------------------------------------------------------------------------
package vn2d_pkg;

  // coordinate format (signed fixed point)
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;

  // lattice cell index and eased fraction widths
  localparam int unsigned CELL_W = 32;
  localparam int unsigned FRAC_W = 16;
  // sign-extended coordinate, wide enough for the floor shift
  localparam int unsigned EXT_W  = COORD_WIDTH + CELL_W;

  // smoothstep: 3*2^16 - 2u needs 18 bits
  localparam int unsigned EASE_K_W = 18;
  localparam logic [EASE_K_W-1:0] EASE_THREE = 18'd196608;

  // pair mixer and finalizer constants
  localparam logic [31:0] HASH_MUL_X = 32'h9E3779B1;
  localparam logic [31:0] HASH_MUL_Y = 32'h85EBCA77;
  localparam logic [31:0] HASH_ADD   = 32'h9E3779B9;
  localparam logic [31:0] FIN_MUL_A  = 32'h7FEB352D;
  localparam logic [31:0] FIN_MUL_B  = 32'h846CA68B;

  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned NUM_STAGES  = 10;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [CELL_W-1:0]             cell_t;
  typedef logic [31:0]                   hash_t;
  typedef logic [FRAC_W-1:0]             frac_t;
  typedef logic signed [15:0]            sample_t;

endpackage

// ===== rtl/value_noise_2d.sv =====
// ----------------------------------------------------------------------------
// value_noise_2d: smoothstep-eased 2d value noise over a hashed lattice
// each input transaction passes through the ten stages below to the output
// throughput: one coordinate per cycle while out_ready_i does not stall it
// each stage holds only while its own result is blocked, so bubbles collapse
// reset: asynchronous, active low; clears the stage valid bits only
// ----------------------------------------------------------------------------
module value_noise_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vn2d_pkg::coord_t   coord_x_i,
  input  vn2d_pkg::coord_t   coord_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vn2d_pkg::sample_t  noise_value_o
);

  import vn2d_pkg::*;

  // --------------------------------------------------------------------------
  // stage valid bits and per-stage load enables
  // a stage loads when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  logic [NUM_STAGES-1:0] v_in;

  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NUM_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // stage 1: split into floor cell and Q0.16 fraction, neighbor cells, 3 - 2u and u*u
  // --------------------------------------------------------------------------
  logic signed [EXT_W-1:0]   ext_x, ext_y, shr_x, shr_y;
  logic [FRAC_BITS+15:0]     fw_x, fw_y;
  frac_t                     fx, fy;
  cell_t                     cx_d, cy_d;

  always_comb begin
    ext_x = EXT_W'(coord_x_i);
    ext_y = EXT_W'(coord_y_i);
    // arithmetic shift is the floor division by 2^FRAC_BITS
    shr_x = ext_x >>> FRAC_BITS;
    shr_y = ext_y >>> FRAC_BITS;
    cx_d  = shr_x[CELL_W-1:0];
    cy_d  = shr_y[CELL_W-1:0];
    // top 16 bits of {frac, zeros}: truncates extra bits, pads missing ones
    fw_x  = {coord_x_i[FRAC_BITS-1:0], 16'h0000};
    fw_y  = {coord_y_i[FRAC_BITS-1:0], 16'h0000};
    fx    = fw_x[FRAC_BITS+15 -: FRAC_W];
    fy    = fw_y[FRAC_BITS+15 -: FRAC_W];
  end

  cell_t               cx0_q, cx1_q, cy0_q, cy1_q;
  logic [31:0]         uux_q, uuy_q;
  logic [EASE_K_W-1:0] kx_q, ky_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cx0_q <= cx_d;
      cx1_q <= cx_d + 32'd1;
      cy0_q <= cy_d;
      cy1_q <= cy_d + 32'd1;
      uux_q <= {16'h0000, fx} * {16'h0000, fx};
      uuy_q <= {16'h0000, fy} * {16'h0000, fy};
      kx_q  <= EASE_THREE - {1'b0, fx, 1'b0};
      ky_q  <= EASE_THREE - {1'b0, fy, 1'b0};
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: coordinate multipliers of the pair mixer, smoothstep product
  // --------------------------------------------------------------------------
  logic [49:0] ez_x, ez_y;
  hash_t       ax_q [2];
  hash_t       by_q [2];
  frac_t       sx_q2, sy_q2;

  always_comb begin
    ez_x = {18'h0, uux_q} * {32'h0, kx_q};
    ez_y = {18'h0, uuy_q} * {32'h0, ky_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ax_q[0] <= cx0_q * HASH_MUL_X;
      ax_q[1] <= cx1_q * HASH_MUL_X;
      by_q[0] <= cy0_q * HASH_MUL_Y;
      by_q[1] <= cy1_q * HASH_MUL_Y;
      // result never exceeds 65535, so bits 49:48 are always zero
      sx_q2   <= ez_x[47:32];
      sy_q2   <= ez_y[47:32];
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: mixer sum per corner, then first finalizer xor-shift
  // corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  // --------------------------------------------------------------------------
  hash_t h3_d [NUM_CORNERS];
  hash_t h3_q [NUM_CORNERS];
  frac_t sx_q3, sy_q3;

  always_comb begin
    hash_t a, m, mix;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      a        = ax_q[k[0]];
      m        = by_q[k[1]] + HASH_ADD + {a[25:0], 6'b000000} + {2'b00, a[31:2]};
      mix      = a ^ m;
      h3_d[k]  = mix ^ {16'h0000, mix[31:16]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      h3_q  <= h3_d;
      sx_q3 <= sx_q2;
      sy_q3 <= sy_q2;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: first finalizer multiply
  // --------------------------------------------------------------------------
  hash_t h4_q [NUM_CORNERS];
  frac_t sx_q4, sy_q4;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        h4_q[k] <= h3_q[k] * FIN_MUL_A;
      end
      sx_q4 <= sx_q3;
      sy_q4 <= sy_q3;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: xor-shift by 15 and second finalizer multiply
  // --------------------------------------------------------------------------
  hash_t h5_q [NUM_CORNERS];
  frac_t sx_q5, sy_q5;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        h5_q[k] <= (h4_q[k] ^ {15'h0000, h4_q[k][31:15]}) * FIN_MUL_B;
      end
      sx_q5 <= sx_q4;
      sy_q5 <= sy_q4;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: last xor-shift, corner value = (hash >> 16) - 32768
  // subtracting 32768 from a 16-bit field just flips its msb
  // --------------------------------------------------------------------------
  hash_t   hf [NUM_CORNERS];
  sample_t cv_q [NUM_CORNERS];
  frac_t   sx_q6, sy_q6;

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      hf[k] = h5_q[k] ^ {16'h0000, h5_q[k][31:16]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        cv_q[k] <= $signed({~hf[k][31], hf[k][30:16]});
      end
      sx_q6 <= sx_q5;
      sy_q6 <= sy_q5;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: x blend products (b - a) * sx for the low and high rows
  // --------------------------------------------------------------------------
  logic signed [16:0] dlo, dhi, sxs;
  logic signed [33:0] plo_q, phi_q;
  sample_t            alo_q, ahi_q;
  frac_t              sy_q7;

  always_comb begin
    dlo = 17'(cv_q[1]) - 17'(cv_q[0]);
    dhi = 17'(cv_q[3]) - 17'(cv_q[2]);
    sxs = $signed({1'b0, sx_q6});
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      plo_q <= 34'(dlo) * 34'(sxs);
      phi_q <= 34'(dhi) * 34'(sxs);
      alo_q <= cv_q[0];
      ahi_q <= cv_q[2];
      sy_q7 <= sy_q6;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: a + floor(p / 2^16); dropping low bits of two's complement floors
  // the sum stays between a and b, so the low 16 bits are exact
  // --------------------------------------------------------------------------
  logic signed [17:0] slo, shi;
  sample_t            lo_q, hi_q;
  frac_t              sy_q8;

  always_comb begin
    slo = 18'(alo_q) + plo_q[33:16];
    shi = 18'(ahi_q) + phi_q[33:16];
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      lo_q  <= slo[15:0];
      hi_q  <= shi[15:0];
      sy_q8 <= sy_q7;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: y blend product (hi - lo) * sy
  // --------------------------------------------------------------------------
  logic signed [16:0] dy, sys;
  logic signed [33:0] py_q;
  sample_t            ay_q;

  always_comb begin
    dy  = 17'(hi_q) - 17'(lo_q);
    sys = $signed({1'b0, sy_q8});
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      py_q <= 34'(dy) * 34'(sys);
      ay_q <= lo_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: final blend into the output register
  // --------------------------------------------------------------------------
  logic signed [17:0] sy_sum;
  sample_t            res_q;

  assign sy_sum = 18'(ay_q) + py_q[33:16];

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      res_q <= sy_sum[15:0];
    end
  end

  assign noise_value_o = res_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // an empty output stage never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage is empty");

  // a transaction in without one out adds exactly one item in flight
  a_occupancy_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_acc) |=> ($countones(v_q) == $past($countones(v_q)) + 1))
    else $error("item lost or duplicated on input transaction");

  // a transaction out without one in removes exactly one item
  a_occupancy_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && out_acc) |=> ($countones(v_q) + 1 == $past($countones(v_q))))
    else $error("item lost or duplicated on output transaction");

endmodule
